[sv/bae_pkg.sv]
package bae_pkg;

    // Prefix storage
    localparam int PREFIX_MAX_CHARS = 8;
    localparam int PREFIX_BITS      = PREFIX_MAX_CHARS * 8;

    // Item queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Checksum and character constants
    localparam logic [29:0] CHECKSUM_INIT  = 30'd1;
    localparam logic [2:0]  CHECK_LAST     = 3'd5;
    localparam logic [6:0]  SEPARATOR_CHAR = 7'h31;

    // Register reset values and register indexes
    localparam logic [PREFIX_BITS-1:0] PREFIX_CHARS_RESET  = PREFIX_BITS'(64'h6362);
    localparam logic [3:0]             PREFIX_LENGTH_RESET = 4'd2;
    localparam logic REG_PREFIX_CHARS  = 1'b0;
    localparam logic REG_PREFIX_LENGTH = 1'b1;

    // Input action codes
    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_BYTE  = 1'b1;

    typedef struct packed {
        logic       is_start;
        logic [7:0] value;
        logic       version_bad;
        logic       last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // One step of the 30-bit BCH checksum
    function automatic logic [29:0] polymod(input logic [29:0] c);
        logic [29:0] r;
        r = {c[24:0], 5'b00000};
        if (c[25]) r = r ^ 30'h3b6a57b2;
        if (c[26]) r = r ^ 30'h26508e6d;
        if (c[27]) r = r ^ 30'h1ea119fa;
        if (c[28]) r = r ^ 30'h3d4233dd;
        if (c[29]) r = r ^ 30'h2a1462b3;
        return r;
    endfunction

    // Map a 5-bit symbol to its character
    function automatic logic [7:0] charset(input logic [4:0] sym);
        logic [7:0] ch;
        case (sym)
            5'd1:    ch = "p";
            5'd2:    ch = "z";
            5'd3:    ch = "r";
            5'd4:    ch = "y";
            5'd5:    ch = "9";
            5'd6:    ch = "x";
            5'd7:    ch = "8";
            5'd8:    ch = "g";
            5'd9:    ch = "f";
            5'd10:   ch = "2";
            5'd11:   ch = "t";
            5'd12:   ch = "v";
            5'd13:   ch = "d";
            5'd14:   ch = "w";
            5'd15:   ch = "0";
            5'd16:   ch = "s";
            5'd17:   ch = "3";
            5'd18:   ch = "j";
            5'd19:   ch = "n";
            5'd20:   ch = "5";
            5'd21:   ch = "4";
            5'd22:   ch = "k";
            5'd23:   ch = "h";
            5'd24:   ch = "c";
            5'd25:   ch = "e";
            5'd26:   ch = "6";
            5'd27:   ch = "m";
            5'd28:   ch = "u";
            5'd29:   ch = "a";
            5'd30:   ch = "7";
            5'd31:   ch = "l";
            default: ch = "q";
        endcase
        return ch;
    endfunction

endpackage

[sv/bae_front.sv]
module bae_front import bae_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] value
    input  logic              s_tuser,   // [0] action
    input  logic              s_tlast,
    output queue_head_t       head,
    input  logic              pop
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    item_t             in_item;

    // Classify the incoming transaction
    always_comb
    begin
        in_item.is_start    = (s_tuser == ACTION_START);
        in_item.value       = s_tdata;
        in_item.version_bad = |s_tdata[7:5];
        in_item.last        = s_tlast;
    end

    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store queued items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(QUEUE_DEPTH)) |-> !push)
        else $error("queue written while full");

endmodule

[sv/bae_back.sv]
module bae_back import bae_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  queue_head_t            head,
    output logic                   pop,
    input  logic [PREFIX_BITS-1:0] prefix_chars,
    input  logic [3:0]             prefix_len,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [6:0] symbol_char, [7] zero
    output logic                   m_tuser,   // [0] error
    output logic                   m_tlast
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HI   = 4'd1;
    localparam logic [3:0] S_MID  = 4'd2;
    localparam logic [3:0] S_LO   = 4'd3;
    localparam logic [3:0] S_SEP  = 4'd4;
    localparam logic [3:0] S_VER  = 4'd5;
    localparam logic [3:0] S_BYTE = 4'd6;
    localparam logic [3:0] S_PAD  = 4'd7;
    localparam logic [3:0] S_TAIL = 4'd8;
    localparam logic [3:0] S_CHK  = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [2:0]  idx_reg, idx_next;
    logic [29:0] cs_reg, cs_next;
    logic [11:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  lo_bits_reg, lo_bits_next;
    logic [2:0]  lc_reg, lc_next;
    logic        err_reg, err_next;
    item_t       cur_reg, cur_next;

    logic        out_valid_reg;
    logic [6:0]  out_char_reg;
    logic        out_err_reg;
    logic        out_end_reg;

    logic        slot_free;
    logic        emit;
    logic [6:0]  emit_char;
    logic        emit_end;
    logic [7:0]  pchar;
    logic        last_idx;
    logic [29:0] poly;
    logic [3:0]  cnt_m5;
    logic [4:0]  sym_byte;
    logic [3:0]  lo_mask;
    logic [4:0]  sym_pad;
    logic [7:0]  ch_byte, ch_pad, ch_ver, ch_chk;

    assign slot_free = !out_valid_reg || m_tready;
    assign pchar     = prefix_chars[{idx_reg, 3'b000} +: 8];
    assign last_idx  = ({1'b0, idx_reg} == (prefix_len - 4'd1));
    assign poly      = polymod(cs_reg);
    assign cnt_m5    = cnt_reg - 4'd5;
    assign sym_byte  = 5'(acc_reg >> cnt_m5);
    assign lo_mask   = (4'd1 << cnt_m5) - 4'd1;
    assign sym_pad   = 5'(5'(lo_bits_reg) << (3'd5 - lc_reg));
    assign ch_byte   = charset(sym_byte);
    assign ch_pad    = charset(sym_pad);
    assign ch_ver    = charset(cur_reg.value[4:0]);
    assign ch_chk    = charset(cs_reg[29:25]);

    // Sequence one item: checksum steps and character emission
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cs_next      = cs_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        lo_bits_next = lo_bits_reg;
        lc_next      = lc_reg;
        err_next     = err_reg;
        cur_next     = cur_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        emit_char    = '0;
        emit_end     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cur_next = head.item;
                    if (head.item.is_start)
                    begin
                        cs_next      = CHECKSUM_INIT;
                        lo_bits_next = '0;
                        lc_next      = '0;
                        err_next     = head.item.version_bad;
                        idx_next     = '0;
                        state_next   = (prefix_len == 4'd0) ? S_MID : S_HI;
                    end
                    else
                    begin
                        acc_next   = {lo_bits_reg, head.item.value};
                        cnt_next   = {1'b0, lc_reg} + 4'd8;
                        state_next = S_BYTE;
                    end
                end
            end
            S_HI:
            begin
                // Fold high bits of each prefix character, flag uppercase
                cs_next  = poly ^ 30'(pchar[7:5]);
                idx_next = idx_reg + 3'd1;
                if (pchar >= 8'h41 && pchar <= 8'h5A)
                begin
                    err_next = 1'b1;
                end
                if (last_idx)
                begin
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                cs_next    = poly;
                idx_next   = '0;
                state_next = (prefix_len == 4'd0) ? S_SEP : S_LO;
            end
            S_LO:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_char = pchar[6:0];
                    cs_next   = poly ^ 30'(pchar[4:0]);
                    idx_next  = idx_reg + 3'd1;
                    if (last_idx)
                    begin
                        state_next = S_SEP;
                    end
                end
            end
            S_SEP:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_char  = SEPARATOR_CHAR;
                    state_next = S_VER;
                end
            end
            S_VER:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_char = ch_ver[6:0];
                    cs_next   = poly ^ 30'(cur_reg.value[4:0]);
                    idx_next  = '0;
                    if (cur_reg.last)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        emit_end   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_BYTE:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_char = ch_byte[6:0];
                    cs_next   = poly ^ 30'(sym_byte);
                    cnt_next  = cnt_m5;
                    if (cnt_m5 < 4'd5)
                    begin
                        lo_bits_next = acc_reg[3:0] & lo_mask;
                        lc_next      = cnt_m5[2:0];
                        idx_next     = '0;
                        if (cur_reg.last)
                        begin
                            state_next = (cnt_m5 != 4'd0) ? S_PAD : S_TAIL;
                        end
                        else
                        begin
                            emit_end   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_PAD:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_char  = ch_pad[6:0];
                    cs_next    = poly ^ 30'(sym_pad);
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                // Six zero steps, then flip the low bit
                lo_bits_next = '0;
                lc_next      = '0;
                idx_next     = idx_reg + 3'd1;
                cs_next      = poly;
                if (idx_reg == CHECK_LAST)
                begin
                    cs_next    = poly ^ CHECKSUM_INIT;
                    idx_next   = '0;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                // Shift out the checksum, top symbol first
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_char = ch_chk[6:0];
                    cs_next   = {cs_reg[24:0], 5'b00000};
                    idx_next  = idx_reg + 3'd1;
                    if (idx_reg == CHECK_LAST)
                    begin
                        emit_end   = 1'b1;
                        cs_next    = CHECKSUM_INIT;
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cs_reg        <= CHECKSUM_INIT;
            cnt_reg       <= '0;
            lo_bits_reg   <= '0;
            lc_reg        <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cs_reg      <= cs_next;
            cnt_reg     <= cnt_next;
            lo_bits_reg <= lo_bits_next;
            lc_reg      <= lc_next;
            err_reg     <= err_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold item payload and output payload
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        cur_reg <= cur_next;
        if (emit)
        begin
            out_char_reg <= emit_char;
            out_err_reg  <= err_reg;
            out_end_reg  <= emit_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_end_reg;

    a_lc_range: assert property (@(posedge clk) disable iff (!rst_n)
        lc_reg <= 3'd4)
        else $error("leftover count out of range");

    a_chk_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (lc_reg == 3'd0 && lo_bits_reg == 4'd0))
        else $error("leftover state not cleared before checksum output");

    a_chk_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK && emit && idx_reg == CHECK_LAST)
        |=> (state_reg == S_IDLE && cs_reg == CHECKSUM_INIT))
        else $error("checksum not restarted after final character");

endmodule

[sv/bech32_address_encoder_core.sv]
// Channel   Dir  tdata                 tuser      tlast
// s_*       in   [7:0] value           [0] action [0] last
// m_*       out  [6:0] symbol_char     [0] error  [0] end_of_run
// apb       in   0x0 prefix_chars (64b), 0x8 prefix_length (4b)
//
// A start transaction for L prefix characters runs L high-bit steps and one
// zero step, then emits one character per cycle while the output is free: L
// prefix characters, the separator and the version. A program byte pops the
// queue, then emits its 5-bit symbols (1 or 2) at the same rate. With last set,
// a byte adds one padding symbol when bits are left over, and either kind adds
// six checksum steps and six characters. One polymod stage in bae_back serves
// every step; a two-entry queue lets input arrive while the back end works, and
// the output register holds a character until taken. Reset sets prefix "bc".
module bech32_address_encoder_core import bae_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] value
    input  logic                   s_tuser,   // [0] action
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [6:0] symbol_char, [7] zero
    output logic                   m_tuser,   // [0] error
    output logic                   m_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [PREFIX_BITS-1:0] pwdata,
    output logic [PREFIX_BITS-1:0] prdata,
    output logic                   pready
);

    logic [PREFIX_BITS-1:0] prefix_chars_reg;
    logic [3:0]             prefix_length_reg;
    logic [3:0]             prefix_len;
    logic                   cfg_write;
    queue_head_t            head;
    logic                   pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_chars_reg  <= PREFIX_CHARS_RESET;
            prefix_length_reg <= PREFIX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == REG_PREFIX_CHARS)
            begin
                prefix_chars_reg <= pwdata;
            end
            else
            begin
                prefix_length_reg <= pwdata[3:0];
            end
        end
    end

    assign prdata = (paddr[3] == REG_PREFIX_LENGTH) ?
                    PREFIX_BITS'(prefix_length_reg) : prefix_chars_reg;

    // Clamp prefix length to the stored character count
    assign prefix_len = (prefix_length_reg > 4'(PREFIX_MAX_CHARS)) ?
                        4'(PREFIX_MAX_CHARS) : prefix_length_reg;

    bae_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .head     (head),
        .pop      (pop)
    );

    bae_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .prefix_chars (prefix_chars_reg),
        .prefix_len   (prefix_len),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule
